### rtl/ife_pkg.sv
package ife_pkg;

    localparam int UNIT_W  = 10;
    localparam int UNITS_W = 6;
    localparam int PROD_W  = UNIT_W + UNITS_W;
    localparam int DUR_W   = 18;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 10;
    localparam int SLOT_W  = 5;

    localparam logic [UNITS_W-1:0] STOP_UNITS = 6'd1;
    localparam logic [DUR_W-1:0]   GAP_US     = 18'd150000;

    // pulse slots of one byte: leader, sixteen bit pulses, stop and gap
    localparam logic [SLOT_W-1:0] SLOT_LEADER   = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_BIT0     = 5'd2;
    localparam logic [SLOT_W-1:0] SLOT_BITS_END = 5'd17;
    localparam logic [SLOT_W-1:0] SLOT_LAST     = 5'd19;

    typedef enum logic [IDX_W-1:0] {
        REG_UNIT_US          = 4'd0,
        REG_LEADER_MARK      = 4'd1,
        REG_LEADER_SPACE     = 4'd2,
        REG_ONE_MARK         = 4'd3,
        REG_ONE_SPACE        = 4'd4,
        REG_ZERO_MARK        = 4'd5,
        REG_ZERO_SPACE       = 4'd6,
        REG_LSB_FIRST        = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [UNIT_W-1:0]  unit_us;
        logic [UNITS_W-1:0] leader_mark_units;
        logic [UNITS_W-1:0] leader_space_units;
        logic [UNITS_W-1:0] one_mark_units;
        logic [UNITS_W-1:0] one_space_units;
        logic [UNITS_W-1:0] zero_mark_units;
        logic [UNITS_W-1:0] zero_space_units;
        logic               lsb_first_mode;
    } cfg_t;

    typedef enum logic [2:0] {
        SRC_LEADER = 3'd0,
        SRC_ONE    = 3'd1,
        SRC_ZERO   = 3'd2,
        SRC_STOP   = 3'd3,
        SRC_GAP    = 3'd4
    } pulse_src_t;

    typedef struct packed {
        logic       valid;
        logic       level;
        pulse_src_t src;
        logic       run_last;
    } pulse_sel_t;

endpackage

### rtl/ife_byte_if.sv
interface ife_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

### rtl/ife_pulse_if.sv
interface ife_pulse_if;
    logic                      valid;
    logic                      ready;
    logic                      pulse_level;
    logic [ife_pkg::DUR_W-1:0] pulse_duration_us;
    logic                      run_last;

    modport source (output valid, output pulse_level, output pulse_duration_us,
                    output run_last, input ready);
    modport sink   (input valid, input pulse_level, input pulse_duration_us,
                    input run_last, output ready);
endinterface

### rtl/ife_cfg_if.sv
interface ife_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ife_pkg::IDX_W-1:0]  index;
    logic [ife_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ir_frame_pulse_encoder.sv
// channel      dir  transaction
// frame_bytes  in   data_byte, first_byte, last_byte
// pulses       out  pulse_level, pulse_duration_us, run_last
// cfg          in   index, data (register write)
//
// one pulse descriptor per cycle while the output does not stall; a byte is 16 to 20
// pulses (16, plus 2 for leader, plus 2 for stop and gap), set by the single pulse slot sequencer
// the next byte is taken in the cycle its predecessor's last pulse is loaded
// the multiply of unit by multiple sits between slot select and output register
// rst_n clears the sequencer and output valid and restores register defaults
// an output stall holds the slot counter, so no pulse is lost
module ir_frame_pulse_encoder (
    input  logic     clk,
    input  logic     rst_n,
    ife_byte_if.sink frame_bytes,
    ife_pulse_if.source pulses,
    ife_cfg_if.sink  cfg
);

    ife_pkg::cfg_t       regs;
    ife_pkg::pulse_sel_t sel;
    logic                advance;

    ife_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ife_pulse_seq u_pulse_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_bytes (frame_bytes),
        .bit0_first  (regs.lsb_first_mode),
        .advance     (advance),
        .sel         (sel)
    );

    ife_pulse_out u_pulse_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (regs),
        .sel     (sel),
        .advance (advance),
        .pulses  (pulses)
    );

endmodule

### rtl/ife_cfg_regs.sv
module ife_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    ife_cfg_if.sink       cfg,
    output ife_pkg::cfg_t regs
);

    ife_pkg::cfg_t regs_reg;
    logic          wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.unit_us            <= 10'd562;
            regs_reg.leader_mark_units  <= 6'd16;
            regs_reg.leader_space_units <= 6'd8;
            regs_reg.one_mark_units     <= 6'd1;
            regs_reg.one_space_units    <= 6'd3;
            regs_reg.zero_mark_units    <= 6'd1;
            regs_reg.zero_space_units   <= 6'd1;
            regs_reg.lsb_first_mode     <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (ife_pkg::reg_idx_t'(cfg.index))
                ife_pkg::REG_UNIT_US:
                    regs_reg.unit_us <= cfg.data[ife_pkg::UNIT_W-1:0];
                ife_pkg::REG_LEADER_MARK:
                    regs_reg.leader_mark_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_LEADER_SPACE:
                    regs_reg.leader_space_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_ONE_MARK:
                    regs_reg.one_mark_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_ONE_SPACE:
                    regs_reg.one_space_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_ZERO_MARK:
                    regs_reg.zero_mark_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_ZERO_SPACE:
                    regs_reg.zero_space_units <= cfg.data[ife_pkg::UNITS_W-1:0];
                ife_pkg::REG_LSB_FIRST:
                    regs_reg.lsb_first_mode <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/ife_pulse_seq.sv
module ife_pulse_seq (
    input  logic                clk,
    input  logic                rst_n,
    ife_byte_if.sink            frame_bytes,
    input  logic                bit0_first,
    input  logic                advance,
    output ife_pkg::pulse_sel_t sel
);

    logic                       busy_reg, busy_next;
    logic [ife_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [7:0]                 byte_reg;
    logic                       first_reg;
    logic                       last_reg;

    logic [ife_pkg::SLOT_W-1:0] end_slot;
    logic [ife_pkg::SLOT_W-1:0] bit_off;
    logic [2:0]                 bit_k;
    logic [2:0]                 bit_pos;
    logic                       finishing;
    logic                       accept;

    assign end_slot  = last_reg ? ife_pkg::SLOT_LAST : ife_pkg::SLOT_BITS_END;
    assign finishing = busy_reg && advance && (pos_reg == end_slot);
    assign frame_bytes.ready = !busy_reg || finishing;
    assign accept    = frame_bytes.valid && frame_bytes.ready;

    assign bit_off = pos_reg - ife_pkg::SLOT_BIT0;
    assign bit_k   = bit_off[3:1];
    assign bit_pos = bit0_first ? bit_k : ~bit_k;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pos_next  = frame_bytes.first_byte ? ife_pkg::SLOT_LEADER : ife_pkg::SLOT_BIT0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && advance)
        begin
            pos_next = pos_reg + ife_pkg::SLOT_W'(1);
        end
    end

    always_comb
    begin
        sel.valid    = busy_reg;
        sel.level    = ~pos_reg[0];
        sel.run_last = (pos_reg == end_slot);
        priority if (pos_reg < ife_pkg::SLOT_BIT0)
            sel.src = ife_pkg::SRC_LEADER;
        else if (pos_reg > ife_pkg::SLOT_BITS_END)
            sel.src = pos_reg[0] ? ife_pkg::SRC_GAP : ife_pkg::SRC_STOP;
        else if (byte_reg[bit_pos])
            sel.src = ife_pkg::SRC_ONE;
        else
            sel.src = ife_pkg::SRC_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= ife_pkg::SLOT_LEADER;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= frame_bytes.data_byte;
            first_reg <= frame_bytes.first_byte;
            last_reg  <= frame_bytes.last_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= end_slot)
        else $error("slot beyond end of run");

    a_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && (pos_reg == ($past(frame_bytes.first_byte)
            ? ife_pkg::SLOT_LEADER : ife_pkg::SLOT_BIT0)))
        else $error("run starts at wrong slot");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !advance |=> busy_reg && $stable(pos_reg))
        else $error("slot moved while output stalled");

    a_leader_only_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (pos_reg < ife_pkg::SLOT_BIT0) |-> first_reg)
        else $error("leader without first byte");
`endif

endmodule

### rtl/ife_pulse_out.sv
module ife_pulse_out (
    input  logic                clk,
    input  logic                rst_n,
    input  ife_pkg::cfg_t       cfg,
    input  ife_pkg::pulse_sel_t sel,
    output logic                advance,
    ife_pulse_if.source         pulses
);

    logic                        valid_reg, valid_next;
    logic                        level_reg;
    logic [ife_pkg::DUR_W-1:0]   dur_reg, dur_next;
    logic                        last_reg;

    logic [ife_pkg::UNITS_W-1:0] units;
    logic [ife_pkg::PROD_W-1:0]  prod;
    logic                        load;

    assign load    = !valid_reg || pulses.ready;
    assign advance = load;

    always_comb
    begin
        unique case (sel.src)
            ife_pkg::SRC_LEADER:
                units = sel.level ? cfg.leader_mark_units : cfg.leader_space_units;
            ife_pkg::SRC_ONE:
                units = sel.level ? cfg.one_mark_units : cfg.one_space_units;
            ife_pkg::SRC_ZERO:
                units = sel.level ? cfg.zero_mark_units : cfg.zero_space_units;
            ife_pkg::SRC_STOP:
                units = ife_pkg::STOP_UNITS;
            default:
                units = '0;
        endcase
    end

    assign prod = {{ife_pkg::UNITS_W{1'b0}}, cfg.unit_us}
                * {{ife_pkg::UNIT_W{1'b0}}, units};

    always_comb
    begin
        if (sel.src == ife_pkg::SRC_GAP)
            dur_next = ife_pkg::GAP_US;
        else
            dur_next = {{(ife_pkg::DUR_W - ife_pkg::PROD_W){1'b0}}, prod};
    end

    assign valid_next = load ? sel.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && sel.valid)
        begin
            level_reg <= sel.level;
            dur_reg   <= dur_next;
            last_reg  <= sel.run_last;
        end
    end

    assign pulses.valid             = valid_reg;
    assign pulses.pulse_level       = level_reg;
    assign pulses.pulse_duration_us = dur_reg;
    assign pulses.run_last          = last_reg;

`ifndef NO_ASSERTIONS
    a_gap_value: assert property (@(posedge clk) disable iff (!rst_n)
        load && sel.valid && (sel.src == ife_pkg::SRC_GAP)
        |=> pulses.valid && !pulses.pulse_level && (pulses.pulse_duration_us == ife_pkg::GAP_US))
        else $error("gap pulse malformed");

    a_level_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load && sel.valid |=> pulses.pulse_level == $past(sel.level))
        else $error("level not taken from selection");

    a_advance_free: assert property (@(posedge clk) disable iff (!rst_n)
        !pulses.valid |-> advance)
        else $error("sequencer held with empty output");
`endif

endmodule

### tb/tb_ir_frame_pulse_encoder.sv
`timescale 1ns / 1ps

module tb_ir_frame_pulse_encoder;
    import ife_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = 4'd15;
    localparam int N_DIRECTED   = 41;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 22;
    localparam int IDLE_PERCENT = 19;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BYTE,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic [7:0]        data_byte;
        logic              first_byte;
        logic              last_byte;
        logic [DUR_W-1:0]  lead_mark;
        logic [DUR_W-1:0]  lead_space;
        logic [DUR_W-1:0]  bit_mark;
        logic [DUR_W-1:0]  bit_space;
        logic [DUR_W-1:0]  stop_mark;
    } step_row_t;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
        logic             run_last;
    } pulse_t;

    logic clk;
    logic rst_n;
    bit   steady;
    int   errors;

    cfg_t      enc_cfg;
    pulse_t    pending_pulses [$];
    step_row_t directed_rows [0:N_DIRECTED-1];

    ife_byte_if  frame_if ();
    ife_pulse_if pulse_if ();
    ife_cfg_if   cfg_if ();

    ir_frame_pulse_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_bytes (frame_if),
        .pulses      (pulse_if),
        .cfg         (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DUR_W-1:0] scaled_us(input logic [UNITS_W-1:0] units);
        scaled_us = DUR_W'(enc_cfg.unit_us) * DUR_W'(units);
    endfunction

    function automatic void queue_pulse_run(input logic f, input logic l,
                                            input logic [DUR_W-1:0] lead_mark,
                                            input logic [DUR_W-1:0] lead_space,
                                            input logic [7:0][DUR_W-1:0] marks,
                                            input logic [7:0][DUR_W-1:0] spaces,
                                            input logic [DUR_W-1:0] stop_mark);
        if (f)
        begin
            pending_pulses.push_back(pulse_t'{1'b1, lead_mark, 1'b0});
            pending_pulses.push_back(pulse_t'{1'b0, lead_space, 1'b0});
        end
        for (int i = 0; i < 8; i++)
        begin
            pending_pulses.push_back(pulse_t'{1'b1, marks[i], 1'b0});
            pending_pulses.push_back(pulse_t'{1'b0, spaces[i], (i == 7) && !l});
        end
        if (l)
        begin
            pending_pulses.push_back(pulse_t'{1'b1, stop_mark, 1'b0});
            pending_pulses.push_back(pulse_t'{1'b0, GAP_US, 1'b1});
        end
    endfunction

    function automatic void encode_byte_pulses(input logic [7:0] d, input logic f,
                                               input logic l);
        logic [7:0][DUR_W-1:0] marks;
        logic [7:0][DUR_W-1:0] spaces;
        logic                  b;
        for (int i = 0; i < 8; i++)
        begin
            b = enc_cfg.lsb_first_mode ? d[i] : d[7 - i];
            marks[i]  = scaled_us(b ? enc_cfg.one_mark_units : enc_cfg.zero_mark_units);
            spaces[i] = scaled_us(b ? enc_cfg.one_space_units : enc_cfg.zero_space_units);
        end
        queue_pulse_run(f, l, scaled_us(enc_cfg.leader_mark_units),
                        scaled_us(enc_cfg.leader_space_units), marks, spaces,
                        scaled_us(STOP_UNITS));
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            frame_if.valid <= 1'b0;
            @(negedge clk);
        end
        frame_if.valid      <= 1'b1;
        frame_if.data_byte  <= d;
        frame_if.first_byte <= f;
        frame_if.last_byte  <= l;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        frame_if.valid <= 1'b0;
        cfg_if.valid   <= 1'b1;
        cfg_if.index   <= idx;
        cfg_if.data    <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_UNIT_US:      enc_cfg.unit_us            = val[UNIT_W-1:0];
            REG_LEADER_MARK:  enc_cfg.leader_mark_units  = val[UNITS_W-1:0];
            REG_LEADER_SPACE: enc_cfg.leader_space_units = val[UNITS_W-1:0];
            REG_ONE_MARK:     enc_cfg.one_mark_units     = val[UNITS_W-1:0];
            REG_ONE_SPACE:    enc_cfg.one_space_units    = val[UNITS_W-1:0];
            REG_ZERO_MARK:    enc_cfg.zero_mark_units    = val[UNITS_W-1:0];
            REG_ZERO_SPACE:   enc_cfg.zero_space_units   = val[UNITS_W-1:0];
            REG_LSB_FIRST:    enc_cfg.lsb_first_mode     = val[0];
            default:          ;
        endcase
    endtask

    task automatic drain_pulses();
        @(negedge clk);
        frame_if.valid <= 1'b0;
        cfg_if.valid   <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        pulse_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        pulse_t want;
        if (rst_n && pulse_if.valid && pulse_if.ready)
        begin
            if (pending_pulses.size() == 0)
            begin
                $display("%0t: unexpected pulse, level %0d duration %0d run_last %0d",
                         $time, pulse_if.pulse_level, pulse_if.pulse_duration_us,
                         pulse_if.run_last);
                errors++;
            end
            else
            begin
                want = pending_pulses.pop_front();
                if (pulse_if.pulse_level !== want.level)
                begin
                    $display("%0t: pulse_level expected %0d actual %0d",
                             $time, want.level, pulse_if.pulse_level);
                    errors++;
                end
                if (pulse_if.pulse_duration_us !== want.duration)
                begin
                    $display("%0t: pulse_duration_us expected %0d actual %0d",
                             $time, want.duration, pulse_if.pulse_duration_us);
                    errors++;
                end
                if (pulse_if.run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %0d actual %0d",
                             $time, want.run_last, pulse_if.run_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        step_row_t         row;
        int                sent;
        int                len;
        bit                noisy;
        logic [7:0]        d;
        logic              f;
        logic              l;
        logic [DATA_W-1:0] v;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        steady              = 1'b0;
        errors              = 0;
        frame_if.valid      = 1'b0;
        frame_if.data_byte  = '0;
        frame_if.first_byte = 1'b0;
        frame_if.last_byte  = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        pulse_if.ready      = 1'b0;

        enc_cfg.unit_us            = 10'd562;
        enc_cfg.leader_mark_units  = 6'd16;
        enc_cfg.leader_space_units = 6'd8;
        enc_cfg.one_mark_units     = 6'd1;
        enc_cfg.one_space_units    = 6'd3;
        enc_cfg.zero_mark_units    = 6'd1;
        enc_cfg.zero_space_units   = 6'd1;
        enc_cfg.lsb_first_mode     = 1'b1;

        directed_rows = '{
            // reset values
            '{ROW_TYPED, '0, '0, 8'h00, 1'b1, 1'b1, 18'd8992, 18'd4496, 18'd562, 18'd562,
              18'd562},
            '{ROW_TYPED, '0, '0, 8'hFF, 1'b1, 1'b0, 18'd8992, 18'd4496, 18'd562, 18'd1686,
              '0},
            '{ROW_BYTE, '0, '0, 8'hA5, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b1, '0, '0, '0, '0, '0},
            // msb first
            '{ROW_CFG, REG_LSB_FIRST, 10'h000, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h01, 1'b1, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b1, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h3C, 1'b1, 1'b1, '0, '0, '0, '0, '0},
            // largest unit and multiples
            '{ROW_CFG, REG_UNIT_US, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LEADER_MARK, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LEADER_SPACE, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_MARK, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_SPACE, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_MARK, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_SPACE, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LSB_FIRST, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_TYPED, '0, '0, 8'h00, 1'b1, 1'b1, 18'd64449, 18'd64449, 18'd64449,
              18'd64449, 18'd1023},
            '{ROW_TYPED, '0, '0, 8'hFF, 1'b1, 1'b1, 18'd64449, 18'd64449, 18'd64449,
              18'd64449, 18'd1023},
            // zero multiples, upper data bits dropped
            '{ROW_CFG, REG_LEADER_MARK, 10'h040, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LEADER_SPACE, 10'h0C0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_MARK, 10'h040, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_SPACE, 10'h3C0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_MARK, 10'h000, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_SPACE, 10'h040, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_TYPED, '0, '0, 8'h5A, 1'b1, 1'b1, '0, '0, '0, '0, 18'd1023},
            // zero unit
            '{ROW_CFG, REG_UNIT_US, 10'h000, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_TYPED, '0, '0, 8'hC3, 1'b1, 1'b1, '0, '0, '0, '0, '0},
            // smallest unit, distinct multiples
            '{ROW_CFG, REG_UNIT_US, 10'h001, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_MARK, 10'h005, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ONE_SPACE, 10'h007, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_MARK, 10'h002, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_ZERO_SPACE, 10'h003, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LEADER_MARK, 10'h00A, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h96, 1'b1, 1'b1, '0, '0, '0, '0, '0},
            // writes to unused indexes leave everything alone
            '{ROW_CFG, REG_UNUSED_HI, 10'h000, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_UNUSED_LO, 10'h3FF, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h6B, 1'b0, 1'b1, '0, '0, '0, '0, '0},
            '{ROW_CFG, REG_LSB_FIRST, 10'h002, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h6B, 1'b1, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, '0, '0, '0, '0, '0},
            '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b1, '0, '0, '0, '0, '0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
            begin
                if (r == 0 || directed_rows[r - 1].kind != ROW_CFG)
                    drain_pulses();
                write_reg(row.index, row.value);
            end
            else
            begin
                send_byte(row.data_byte, row.first_byte, row.last_byte);
                if (row.kind == ROW_TYPED)
                    queue_pulse_run(row.first_byte, row.last_byte, row.lead_mark,
                                    row.lead_space, {8{row.bit_mark}}, {8{row.bit_space}},
                                    row.stop_mark);
                else
                    encode_byte_pulses(row.data_byte, row.first_byte, row.last_byte);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pulses();
            steady = (phase == 2);
            case ($urandom_range(3))
                0:       v = 10'd1;
                1:       v = 10'd1023;
                default: v = DATA_W'($urandom_range(1023, 1));
            endcase
            write_reg(REG_UNIT_US, v);
            for (int r = int'(REG_LEADER_MARK); r <= int'(REG_ZERO_SPACE); r++)
            begin
                v = DATA_W'($urandom);
                case ($urandom_range(4))
                    0:       v[UNITS_W-1:0] = '0;
                    1:       v[UNITS_W-1:0] = '1;
                    default: ;
                endcase
                write_reg(IDX_W'(r), v);
            end
            write_reg(REG_LSB_FIRST, DATA_W'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                          DATA_W'($urandom));

            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                len   = $urandom_range(4, 1);
                noisy = ($urandom_range(99) < 20);
                for (int k = 0; k < len; k++)
                begin
                    d = 8'($urandom);
                    f = noisy ? 1'($urandom_range(1)) : (k == 0);
                    l = noisy ? 1'($urandom_range(1)) : (k == len - 1);
                    send_byte(d, f, l);
                    encode_byte_pulses(d, f, l);
                    sent++;
                end
            end
        end

        drain_pulses();
        steady = 1'b0;
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/ife_pkg.sv
rtl/ife_byte_if.sv
rtl/ife_pulse_if.sv
rtl/ife_cfg_if.sv
rtl/ife_cfg_regs.sv
rtl/ife_pulse_seq.sv
rtl/ife_pulse_out.sv
rtl/ir_frame_pulse_encoder.sv
tb/tb_ir_frame_pulse_encoder.sv
